@@ src/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/spq_pkg.sv @@
package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        SPQ_OK        = 2'd0,
        SPQ_DROP_FULL = 2'd1,
        SPQ_DEL_EMPTY = 2'd2
    } t_spq_status;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic [DATA_W-1:0] value;
    } t_spq_cmd;

endpackage

@@ src/spq_cell.sv @@
module spq_cell
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  t_spq_cmd          i_cmd,
    input  logic              i_occ,
    input  logic              i_left_le,
    input  logic [DATA_W-1:0] i_left_value,
    input  logic [DATA_W-1:0] i_right_value,
    output logic [DATA_W-1:0] o_value,
    output logic              o_le
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // Occupied and not greater than the new value: stays in place on insert.
    assign o_le    = i_occ && ($signed(r_value) <= $signed(i_cmd.value));
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.insert && !o_le) begin
            // first cell past the boundary takes the new value, the rest shift up
            n_value = i_left_le ? i_cmd.value : i_left_value;
        end else if (i_cmd.remove) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ src/sorted_priority_queue.sv @@
// Sorted min-priority queue built as a chain of compare-and-shift cells.
// Input channel s_*: tuser[0] is the opcode (insert / delete minimum),
// tdata[31:0] the signed value to insert (ignored on delete).
// Output channel m_*: one transfer per accepted input, describing the queue
// after the operation: minimum (0 when empty), count, empty, full, status.
// Each cell compares its entry with the broadcast value and either holds,
// takes the new value or takes its left neighbor's entry; a delete shifts
// every entry one cell toward the head. Each operation updates the cells and
// the result register together, so the block takes one transfer per cycle
// unless the receiver stalls. The result is on m_tdata the cycle after the
// input transfer. A one-deep output register decouples the sides: input is
// taken while the result register is empty or being read in the same cycle.
// If the receiver stalls, the result holds and s_tready drops.
// Insert into a full queue is dropped (status 1); delete on an empty queue
// does nothing (status 2). Reset empties the queue; entries are not cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] min_value, [36:32] entry_total,
                                   // [37] is_empty, [38] is_full, [40:39] status
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_min;
    logic [DATA_W-1:0] n_min;
    logic [TOTAL_W-1:0] r_total;
    logic              r_empty;
    logic              r_full;
    t_spq_status       r_status;
    t_spq_status       n_status;

    logic              s_fire;
    logic              q_full;
    logic              q_empty;
    t_spq_cmd          cmd;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic              cell_le    [CAPACITY];
    logic              cell_occ   [CAPACITY];

    assign s_tready = !r_out_valid || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign q_full   = (r_count == CNT_W'(CAPACITY));
    assign q_empty  = (r_count == '0);

    assign cmd.insert = s_fire && (s_tuser[0] == OP_INSERT) && !q_full;
    assign cmd.remove = s_fire && (s_tuser[0] == OP_DELETE) && !q_empty;
    assign cmd.value  = s_tdata[DATA_W-1:0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic              left_le;
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        assign cell_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_le    = 1'b0;
            assign left_value = cmd.value;
        end else begin : g_body
            assign left_le    = cell_le[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = '0;
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occ         (cell_occ[g]),
            .i_left_le     (left_le),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_le          (cell_le[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = SPQ_OK;
        n_min    = q_empty ? '0 : cell_value[0];
        if (cmd.insert) begin
            n_count = r_count + CNT_W'(1);
            n_min   = cell_le[0] ? cell_value[0] : cmd.value;
        end else if (cmd.remove) begin
            n_count = r_count - CNT_W'(1);
            n_min   = (r_count > CNT_W'(1)) ? cell_value[1] : '0;
        end else if (s_tuser[0] == OP_INSERT) begin
            n_status = SPQ_DROP_FULL;
        end else begin
            n_status = SPQ_DEL_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_count <= n_count;
            end
            if (s_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_min    <= n_min;
            r_total  <= TOTAL_W'(n_count);
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == CNT_W'(CAPACITY));
            r_status <= n_status;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'b0, r_status, r_full, r_empty, r_total, r_min};

    `SPQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, cmd.remove,
                     r_count == $past(r_count) - CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready, $stable(r_count))
    `SPQ_ASSERT_IMPL(a_flags_match, i_clk, i_rst_n, m_tvalid,
                     !(r_empty && r_full) && (r_empty == (r_min == '0 && r_empty)))

endmodule

@@ dv/spq_checker.sv @@
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [0:0]  i_s_tuser,   // [0] opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // [31:0] min_value, [36:32] entry_total,
                                     // [37] is_empty, [38] is_full, [40:39] status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_drop_count,
    output int          o_ignore_count,
    output int          o_full_count
);

    typedef struct {
        logic signed [DATA_W-1:0] min_value;
        logic [TOTAL_W-1:0]       entry_total;
        logic                     is_empty;
        logic                     is_full;
        t_spq_status              status;
    } t_queue_view;

    logic signed [DATA_W-1:0] held [CAPACITY];
    int                       held_count = 0;
    t_queue_view              view_q [$];
    int                       fails = 0;
    int                       results = 0;
    int                       drops = 0;
    int                       ignores = 0;
    int                       fulls = 0;

    // Apply one operation to the sorted copy and return the queue as seen after it.
    task automatic apply_op(input logic op, input logic signed [DATA_W-1:0] val,
                            output t_queue_view view);
        int pos;
        int i;
        view.status = SPQ_OK;
        if (op == OP_INSERT) begin
            if (held_count >= CAPACITY) begin
                view.status = SPQ_DROP_FULL;
            end else begin
                // go after every entry less than or equal to the new value
                pos = 0;
                while (pos < held_count && held[pos] <= val)
                    pos++;
                for (i = held_count; i > pos; i--)
                    held[i] = held[i-1];
                held[pos] = val;
                held_count++;
            end
        end else if (held_count == 0) begin
            view.status = SPQ_DEL_EMPTY;
        end else begin
            for (i = 1; i < held_count; i++)
                held[i-1] = held[i];
            held_count--;
        end
        view.min_value   = (held_count > 0) ? held[0] : '0;
        view.entry_total = TOTAL_W'(held_count);
        view.is_empty    = (held_count == 0);
        view.is_full     = (held_count >= CAPACITY);
    endtask

    always @(posedge i_clk) begin : watch
        t_queue_view next_view;
        t_queue_view want;
        if (!i_rst_n) begin
            held_count = 0;
            view_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                apply_op(i_s_tuser[0], i_s_tdata, next_view);
                view_q.push_back(next_view);
            end
            if (i_m_tvalid && i_m_tready) begin
                results++;
                if (view_q.size() == 0) begin
                    $error("result transfer with no operation pending: m_tdata=%h", i_m_tdata);
                    fails++;
                end else begin
                    want = view_q.pop_front();
                    if (want.status == SPQ_DROP_FULL) drops++;
                    if (want.status == SPQ_DEL_EMPTY) ignores++;
                    if (want.is_full) fulls++;
                    if (i_m_tdata[31:0] !== want.min_value) begin
                        $error("min_value: expected %0d, actual %0d",
                               want.min_value, $signed(i_m_tdata[31:0]));
                        fails++;
                    end
                    if (i_m_tdata[36:32] !== want.entry_total) begin
                        $error("entry_total: expected %0d, actual %0d",
                               want.entry_total, i_m_tdata[36:32]);
                        fails++;
                    end
                    if (i_m_tdata[37] !== want.is_empty) begin
                        $error("is_empty: expected %0b, actual %0b",
                               want.is_empty, i_m_tdata[37]);
                        fails++;
                    end
                    if (i_m_tdata[38] !== want.is_full) begin
                        $error("is_full: expected %0b, actual %0b",
                               want.is_full, i_m_tdata[38]);
                        fails++;
                    end
                    if (i_m_tdata[40:39] !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_m_tdata[40:39]);
                        fails++;
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= view_q.size();
        o_result_count <= results;
        o_drop_count   <= drops;
        o_ignore_count <= ignores;
        o_full_count   <= fulls;
    end

endmodule

@@ dv/sorted_priority_queue_test.sv @@
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASES      = 13;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = OP_INSERT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic        send_idle_on = 1'b1;
    logic        recv_idle_on = 1'b1;
    int          cycles       = 0;
    int          sent         = 0;
    int          fail_count;
    int          pending;
    int          result_count;
    int          drop_count;
    int          ignore_count;
    int          full_count;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    spq_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_drop_count  (drop_count),
        .o_ignore_count(ignore_count),
        .o_full_count  (full_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= !recv_idle_on || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("sorted_priority_queue: mismatch");
            $finish;
        end
    end

    // Present one operation and hold it until the transfer happens.
    task automatic push_op(input logic op, input logic [31:0] val);
        while (send_idle_on && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= val;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        sent++;
    endtask

    // Hold off the sender until every pending result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Mostly full-range values, with clusters of duplicates and the signed extremes.
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom();
        if (roll < 85)
            return $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0001;
            3:       return 32'h7fff_fffe;
            default: return 32'h0000_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] fill_vals [16];
        int          insert_pct [5];
        int          ph;
        int          k;

        fill_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                      32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h7fff_ffff,
                      32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
                      32'hffff_fffe, 32'h0000_0005, 32'h8000_0001, 32'h7fff_fffe};
        insert_pct = '{15, 85, 50, 90, 30};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // delete on empty, fill to capacity with extremes and equal values,
        // insert into a full queue, then a few deletes
        push_op(OP_DELETE, 32'hdead_beef);
        for (k = 0; k < CAPACITY; k++)
            push_op(OP_INSERT, fill_vals[k]);
        push_op(OP_INSERT, 32'h8000_0000);
        repeat (3) push_op(OP_DELETE, $urandom());
        drain_results();

        for (ph = 0; ph < PHASES; ph++) begin
            send_idle_on <= !(ph == 5 || ph == 6);
            recv_idle_on <= !(ph == 5 || ph == 6);
            if (ph == 7)
                drain_results();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < insert_pct[ph % 5])
                    push_op(OP_INSERT, pick_value());
                else
                    push_op(OP_DELETE, $urandom());
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("ran %0d operations, checked %0d results in %0d cycles", sent, result_count,
                 cycles);
        $display("saw %0d dropped inserts, %0d ignored deletes, %0d results with the queue full",
                 drop_count, ignore_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("sorted_priority_queue: match");
        else
            $display("sorted_priority_queue: mismatch");
        $finish;
    end

endmodule
